[rtl/core/tss_pkg.sv]
// Shared types and constants of the two-level thread scheduler.
package tss_pkg;

    localparam int MAX_THREADS = 16;
    localparam int SLOT_W      = $clog2(MAX_THREADS);
    localparam int CNT_W       = $clog2(MAX_THREADS + 1);
    localparam int BUDGET_BITS = 20;
    localparam int QUANT_W     = 8;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 20;

    localparam logic [QUANT_W-1:0]     QUANTUM_RESET = QUANT_W'(10);
    localparam logic [BUDGET_BITS-1:0] HIGH_BUDGET_RESET = BUDGET_BITS'(195);

    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_BUDGET = CFG_IDX_W'(1);

    typedef enum logic [2:0] {
        K_CREATE   = 3'd0,
        K_TICK     = 3'd1,
        K_DISK_REQ = 3'd2,
        K_DISK_DONE = 3'd3,
        K_EXIT     = 3'd4,
        K_SET_PRIO = 3'd5
    } t_kind;

    typedef enum logic [3:0] {
        EV_NONE        = 4'd0,
        EV_CREATED     = 4'd1,
        EV_CREATE_FAIL = 4'd2,
        EV_SWITCH      = 4'd3,
        EV_EJECT       = 4'd4,
        EV_FINISH      = 4'd5,
        EV_BLOCK       = 4'd6,
        EV_WOKEN       = 4'd7,
        EV_ALL_DONE    = 4'd8
    } t_event;

    typedef enum logic [1:0] {
        ST_FREE  = 2'd0,
        ST_READY = 2'd1,
        ST_RUN   = 2'd2,
        ST_WAIT  = 2'd3
    } t_slot_st;

    typedef enum logic [2:0] {
        S_IDLE, S_LOW, S_HI1, S_HI2, S_DISP, S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]  kind;
        logic        priority_req;
        logic [19:0] total_ticks;
        logic        data_cached;
    } t_in;

    typedef struct packed {
        logic [3:0] event_res;
        logic [3:0] running_id;
        logic       cpu_idle;
        logic [3:0] subject_id;
    } t_out;

    typedef struct packed {
        logic                   valid;
        logic [SLOT_W-1:0]      id;
        logic [BUDGET_BITS-1:0] key;
    } t_ent;

endpackage

[rtl/core/tss_cell.sv]
// One cell of a sorted shift queue: holds one entry, shifts in from its neighbors.
module tss_cell
    import tss_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_ent i_left,
    input  logic i_left_open,
    input  t_ent i_right,
    input  t_ent i_new,
    input  logic i_ins,
    input  logic i_pop,
    output t_ent o_ent,
    output logic o_open
);

    t_ent r_ent;

    assign o_open = !r_ent.valid || (r_ent.key > i_new.key);
    assign o_ent  = r_ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent <= '0;
        end else if (i_pop) begin
            r_ent <= i_right;
        end else if (i_ins) begin
            if (i_left_open && i_left.valid) begin
                r_ent <= i_left;
            end else if (o_open && !i_left_open) begin
                r_ent <= i_new;
            end
        end
    end

endmodule

[rtl/core/tss_queue.sv]
// Chain of cells forming a sorted queue; all-ones keys give plain FIFO order.
module tss_queue
    import tss_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  logic [SLOT_W-1:0]      i_push_id,
    input  logic [BUDGET_BITS-1:0] i_push_key,
    input  logic                   i_pop,
    output logic [SLOT_W-1:0]      o_head_id,
    output logic [CNT_W-1:0]       o_count
);

    t_ent w_ent  [MAX_THREADS];
    logic w_open [MAX_THREADS];
    t_ent w_new;
    logic r_unused_full;
    logic [CNT_W-1:0] r_count;
    logic w_ins;

    assign w_new.valid = 1'b1;
    assign w_new.id    = i_push_id;
    assign w_new.key   = i_push_key;
    assign w_ins       = i_push && (r_count != CNT_W'(MAX_THREADS));
    assign r_unused_full = 1'b0;

    for (genvar i = 0; i < MAX_THREADS; i++) begin : g_cell
        t_ent w_left;
        t_ent w_right;
        logic w_lopen;
        if (i == 0) begin : g_first
            assign w_left  = '0;
            assign w_lopen = r_unused_full;
        end else begin : g_mid
            assign w_left  = w_ent[i-1];
            assign w_lopen = w_open[i-1];
        end
        if (i == MAX_THREADS - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_nxt
            assign w_right = w_ent[i+1];
        end
        tss_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_left      (w_left),
            .i_left_open (w_lopen),
            .i_right     (w_right),
            .i_new       (w_new),
            .i_ins       (w_ins),
            .i_pop       (i_pop),
            .o_ent       (w_ent[i]),
            .o_open      (w_open[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_pop && r_count != '0) begin
            r_count <= r_count - CNT_W'(1);
        end else if (w_ins) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    assign o_head_id = w_ent[0].id;
    assign o_count   = r_count;

endmodule

[rtl/core/two_level_sjf_rr_thread_scheduler_top.sv]
// Top level of the two-level thread scheduler.
//
// Input channel: present an item on i_item with start high; it is taken at a
// rising edge where start is high and busy is low. busy stays high until the
// result has been shown.
// Result channel: o_res_valid is high for exactly one cycle with o_res; the
// receiver cannot stall, so the result is taken in that cycle.
// A new item is taken only after the previous result has been shown, since busy
// drops the cycle after the result.
// The sequencer walks a low-queue push, two high-list inserts, a dispatch and
// the result cycle; each queue is a chain of cells that inserts or shifts once
// per cycle.
// Configuration: i_cfg_valid/o_cfg_ready with i_cfg_idx and i_cfg_data;
// ready is always high. Index 0 is the time slice, index 1 the high budget.
// Reset (synchronous, i_rst_n low): all slots free and low priority, all
// queues empty, cpu idle, registers back to 10 and 195.
module two_level_sjf_rr_thread_scheduler_top
    import tss_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_in                   i_item,
    output logic                  o_res_valid,
    output t_out                  o_res,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_state r_state;
    t_state n_state;

    logic [QUANT_W-1:0]     r_quantum_cfg;
    logic [BUDGET_BITS-1:0] r_high_budget;

    t_slot_st               r_status [MAX_THREADS];
    logic                   r_prio   [MAX_THREADS];
    logic [QUANT_W-1:0]     r_quant  [MAX_THREADS];
    logic [BUDGET_BITS-1:0] r_budget [MAX_THREADS];

    logic [SLOT_W-1:0] r_cur;
    logic              r_idle;

    logic                   r_lp_en, r_lp_req;
    logic [SLOT_W-1:0]      r_lp_id;
    logic                   r_h1_en, r_h2_en;
    logic [SLOT_W-1:0]      r_h1_id, r_h2_id;
    logic [BUDGET_BITS-1:0] r_h1_key, r_h2_key;
    logic                   r_disp_en, r_retire;
    t_event                 r_ev;
    logic [SLOT_W-1:0]      r_subj;

    logic              w_accept;
    logic              w_free_found;
    logic [SLOT_W-1:0] w_free_id;
    t_kind             w_kind;

    logic [SLOT_W-1:0] w_hi_head, w_lo_head, w_wt_head;
    logic [CNT_W-1:0]  w_hi_cnt, w_lo_cnt, w_wt_cnt;
    logic              w_hi_push, w_hi_pop, w_lo_push, w_lo_pop;
    logic              w_wt_push, w_wt_pop;
    logic [SLOT_W-1:0]      w_hi_id;
    logic [BUDGET_BITS-1:0] w_hi_key;
    logic              w_pick_hi, w_pick_lo;

    assign w_accept    = start && (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_kind      = t_kind'(i_item.kind);

    always_comb begin
        w_free_found = 1'b0;
        w_free_id    = '0;
        for (int i = MAX_THREADS - 1; i >= 0; i--) begin
            if (r_status[i] == ST_FREE) begin
                w_free_found = 1'b1;
                w_free_id    = SLOT_W'(i);
            end
        end
    end

    assign w_pick_hi = (r_state == S_DISP) && r_disp_en && (w_hi_cnt != '0);
    assign w_pick_lo = (r_state == S_DISP) && r_disp_en && (w_hi_cnt == '0)
                       && (w_lo_cnt != '0);
    assign w_hi_push = ((r_state == S_HI1) && r_h1_en) || ((r_state == S_HI2) && r_h2_en);
    assign w_hi_id   = (r_state == S_HI1) ? r_h1_id : r_h2_id;
    assign w_hi_key  = (r_state == S_HI1) ? r_h1_key : r_h2_key;
    assign w_hi_pop  = w_pick_hi;
    assign w_lo_push = (r_state == S_LOW) && r_lp_en;
    assign w_lo_pop  = w_pick_lo;
    assign w_wt_push = w_accept && (w_kind == K_DISK_REQ) && !r_idle && !i_item.data_cached;
    assign w_wt_pop  = w_accept && (w_kind == K_DISK_DONE) && (w_wt_cnt != '0);

    tss_queue u_high (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_push (w_hi_push), .i_push_id (w_hi_id), .i_push_key (w_hi_key),
        .i_pop (w_hi_pop), .o_head_id (w_hi_head), .o_count (w_hi_cnt)
    );

    tss_queue u_low (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_push (w_lo_push), .i_push_id (r_lp_id), .i_push_key ('1),
        .i_pop (w_lo_pop), .o_head_id (w_lo_head), .o_count (w_lo_cnt)
    );

    tss_queue u_wait (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_push (w_wt_push), .i_push_id (r_cur), .i_push_key ('1),
        .i_pop (w_wt_pop), .o_head_id (w_wt_head), .o_count (w_wt_cnt)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (start) n_state = S_LOW;
            S_LOW:  n_state = S_HI1;
            S_HI1:  n_state = S_HI2;
            S_HI2:  n_state = S_DISP;
            S_DISP: n_state = S_DONE;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum_cfg <= QUANTUM_RESET;
            r_high_budget <= HIGH_BUDGET_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_idx == CFG_QUANTUM) begin
                r_quantum_cfg <= i_cfg_data[QUANT_W-1:0];
            end else if (i_cfg_idx == CFG_HIGH_BUDGET) begin
                r_high_budget <= i_cfg_data[BUDGET_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_THREADS; i++) begin
                r_status[i] <= ST_FREE;
                r_prio[i]   <= 1'b0;
            end
            r_cur     <= '0;
            r_idle    <= 1'b1;
            r_lp_en   <= 1'b0;
            r_lp_req  <= 1'b0;
            r_h1_en   <= 1'b0;
            r_h2_en   <= 1'b0;
            r_disp_en <= 1'b0;
            r_retire  <= 1'b0;
            r_ev      <= EV_NONE;
            r_subj    <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_lp_en   <= 1'b0;
                        r_lp_req  <= 1'b0;
                        r_h1_en   <= 1'b0;
                        r_h2_en   <= 1'b0;
                        r_disp_en <= 1'b0;
                        r_retire  <= 1'b0;
                        r_ev      <= EV_NONE;
                        r_subj    <= '0;
                        priority case (w_kind)
                            K_CREATE: begin
                                if (!w_free_found) begin
                                    r_ev <= EV_CREATE_FAIL;
                                end else begin
                                    r_ev   <= EV_CREATED;
                                    r_subj <= w_free_id;
                                    r_quant[w_free_id]  <= r_quantum_cfg;
                                    r_prio[w_free_id]   <= i_item.priority_req;
                                    r_budget[w_free_id] <= i_item.total_ticks[BUDGET_BITS-1:0];
                                    r_status[w_free_id] <= ST_READY;
                                    r_h1_id  <= w_free_id;
                                    r_h1_key <= i_item.total_ticks[BUDGET_BITS-1:0];
                                    if (!i_item.priority_req) begin
                                        r_lp_en <= 1'b1;
                                        r_lp_id <= w_free_id;
                                    end else if (!r_idle && !r_prio[r_cur]) begin
                                        r_lp_en   <= 1'b1;
                                        r_lp_req  <= 1'b1;
                                        r_lp_id   <= r_cur;
                                        r_h1_en   <= 1'b1;
                                        r_disp_en <= 1'b1;
                                    end else if (!r_idle && r_budget[r_cur]
                                                 > i_item.total_ticks[BUDGET_BITS-1:0]) begin
                                        r_h1_en   <= 1'b1;
                                        r_h2_en   <= 1'b1;
                                        r_h2_id   <= r_cur;
                                        r_h2_key  <= r_budget[r_cur];
                                        r_disp_en <= 1'b1;
                                    end else begin
                                        r_h1_en <= 1'b1;
                                    end
                                end
                            end
                            K_TICK: begin
                                if (r_idle) begin
                                    if (w_hi_cnt != '0 || w_lo_cnt != '0) begin
                                        r_disp_en <= 1'b1;
                                        r_ev      <= EV_SWITCH;
                                    end
                                end else if (r_budget[r_cur] == '0) begin
                                    r_subj    <= r_cur;
                                    r_ev      <= EV_EJECT;
                                    r_retire  <= 1'b1;
                                    r_disp_en <= 1'b1;
                                    r_status[r_cur] <= ST_FREE;
                                end else begin
                                    r_budget[r_cur] <= r_budget[r_cur] - BUDGET_BITS'(1);
                                    if (!r_prio[r_cur]) begin
                                        if (r_quant[r_cur] <= QUANT_W'(1)) begin
                                            r_lp_en   <= 1'b1;
                                            r_lp_req  <= 1'b1;
                                            r_lp_id   <= r_cur;
                                            r_disp_en <= 1'b1;
                                            r_ev      <= EV_SWITCH;
                                        end else begin
                                            r_quant[r_cur] <= r_quant[r_cur] - QUANT_W'(1);
                                        end
                                    end
                                end
                            end
                            K_DISK_REQ: begin
                                if (!r_idle && !i_item.data_cached) begin
                                    r_status[r_cur] <= ST_WAIT;
                                    r_disp_en <= 1'b1;
                                    r_ev      <= EV_BLOCK;
                                    r_subj    <= r_cur;
                                end
                            end
                            K_DISK_DONE: begin
                                if (w_wt_cnt != '0 && r_status[w_wt_head] == ST_WAIT) begin
                                    r_ev   <= EV_WOKEN;
                                    r_subj <= w_wt_head;
                                    r_status[w_wt_head] <= ST_READY;
                                    if (!r_prio[w_wt_head]) begin
                                        r_lp_en <= 1'b1;
                                        r_lp_id <= w_wt_head;
                                    end else begin
                                        r_h1_en  <= 1'b1;
                                        r_h1_id  <= w_wt_head;
                                        r_h1_key <= r_budget[w_wt_head];
                                        if (!r_idle && !r_prio[r_cur]) begin
                                            r_lp_en   <= 1'b1;
                                            r_lp_req  <= 1'b1;
                                            r_lp_id   <= r_cur;
                                            r_disp_en <= 1'b1;
                                        end
                                    end
                                end
                            end
                            K_EXIT: begin
                                if (!r_idle) begin
                                    r_subj    <= r_cur;
                                    r_ev      <= EV_FINISH;
                                    r_retire  <= 1'b1;
                                    r_disp_en <= 1'b1;
                                    r_status[r_cur] <= ST_FREE;
                                end
                            end
                            K_SET_PRIO: begin
                                if (!r_idle) begin
                                    r_prio[r_cur] <= i_item.priority_req;
                                    if (i_item.priority_req) begin
                                        r_budget[r_cur] <= r_high_budget;
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_LOW: begin
                    if (r_lp_en) begin
                        r_status[r_lp_id] <= ST_READY;
                        if (r_lp_req) begin
                            r_quant[r_lp_id] <= r_quantum_cfg;
                        end
                    end
                end
                S_HI1: begin
                    if (r_h1_en) begin
                        r_status[r_h1_id] <= ST_READY;
                    end
                end
                S_HI2: begin
                    if (r_h2_en) begin
                        r_status[r_h2_id] <= ST_READY;
                    end
                end
                S_DISP: begin
                    if (r_disp_en) begin
                        if (w_pick_hi) begin
                            r_cur  <= w_hi_head;
                            r_idle <= 1'b0;
                            r_status[w_hi_head] <= ST_RUN;
                        end else if (w_pick_lo) begin
                            r_cur  <= w_lo_head;
                            r_idle <= 1'b0;
                            r_status[w_lo_head] <= ST_RUN;
                        end else begin
                            r_cur  <= '0;
                            r_idle <= 1'b1;
                        end
                    end
                end
                S_DONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        busy        = (r_state != S_IDLE);
        o_res_valid = (r_state == S_DONE);
        o_res.event_res  = (r_retire && r_idle && w_wt_cnt == '0) ? EV_ALL_DONE : r_ev;
        o_res.running_id = r_idle ? 4'd0 : 4'(r_cur);
        o_res.cpu_idle   = r_idle;
        o_res.subject_id = 4'(r_subj);
    end

endmodule

[sim/tb_two_level_sjf_rr_thread_scheduler_top.sv]
// Self-checking testbench of the two-level SJF / round-robin thread scheduler.
`timescale 1ns / 1ps

module tb_two_level_sjf_rr_thread_scheduler_top;
    import tss_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_in                   i_item;
    logic                  o_res_valid;
    t_out                  o_res;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    two_level_sjf_rr_thread_scheduler_top dut (.*);

    // scheduler shadow state
    logic [QUANT_W-1:0]     m_quantum;
    logic [BUDGET_BITS-1:0] m_high_budget;
    t_slot_st               m_status   [MAX_THREADS];
    logic                   m_prio     [MAX_THREADS];
    logic [QUANT_W-1:0]     m_qleft    [MAX_THREADS];
    logic [BUDGET_BITS-1:0] m_budget   [MAX_THREADS];
    logic [SLOT_W-1:0]      m_high     [MAX_THREADS];
    int                     m_high_cnt;
    logic [SLOT_W-1:0]      m_low      [MAX_THREADS];
    logic [SLOT_W-1:0]      m_low_head;
    int                     m_low_cnt;
    logic [SLOT_W-1:0]      m_wait     [MAX_THREADS];
    logic [SLOT_W-1:0]      m_wait_head;
    int                     m_wait_cnt;
    logic [SLOT_W-1:0]      m_cur;
    logic                   m_idle;

    t_out expected_events[$];
    int   n_fail;
    int   n_items;
    int   n_events;
    int   event_seen[16];

    typedef struct {
        t_in  it;
        bit   typed;
        t_out res;
    } t_row;

    function automatic void sched_reset();
        m_quantum     = QUANTUM_RESET;
        m_high_budget = HIGH_BUDGET_RESET;
        for (int i = 0; i < MAX_THREADS; i++) begin
            m_status[i] = ST_FREE;
            m_prio[i]   = 1'b0;
        end
        m_high_cnt  = 0;
        m_low_head  = '0;
        m_low_cnt   = 0;
        m_wait_head = '0;
        m_wait_cnt  = 0;
        m_cur       = '0;
        m_idle      = 1'b1;
    endfunction

    function automatic void high_insert(logic [SLOT_W-1:0] s);
        int i;
        i = m_high_cnt;
        while (i > 0 && m_budget[m_high[i-1]] > m_budget[s]) begin
            m_high[i] = m_high[i-1];
            i--;
        end
        m_high[i] = s;
        m_high_cnt++;
        m_status[s] = ST_READY;
    endfunction

    function automatic void low_push(logic [SLOT_W-1:0] s);
        m_status[s] = ST_READY;
        m_low[SLOT_W'(m_low_head + m_low_cnt)] = s;
        m_low_cnt++;
    endfunction

    function automatic void requeue_low(logic [SLOT_W-1:0] s);
        m_qleft[s] = m_quantum;
        low_push(s);
    endfunction

    function automatic void dispatch_next();
        logic [SLOT_W-1:0] s;
        if (m_high_cnt > 0) begin
            s = m_high[0];
            for (int i = 0; i < MAX_THREADS - 1; i++) m_high[i] = m_high[i+1];
            m_high_cnt--;
        end else if (m_low_cnt > 0) begin
            s = m_low[m_low_head];
            m_low_head++;
            m_low_cnt--;
        end else begin
            m_idle = 1'b1;
            m_cur  = '0;
            return;
        end
        m_cur       = s;
        m_idle      = 1'b0;
        m_status[s] = ST_RUN;
    endfunction

    function automatic t_event retire_current(t_event ev);
        m_status[m_cur] = ST_FREE;
        dispatch_next();
        if (m_idle && m_wait_cnt == 0) return EV_ALL_DONE;
        return ev;
    endfunction

    function automatic t_out sched_predict(t_in it);
        t_event            ev;
        logic [SLOT_W-1:0] subj, s, c;
        int                f;
        t_out              r;
        ev   = EV_NONE;
        subj = '0;
        c    = m_cur;
        case (it.kind)
            K_CREATE: begin
                f = -1;
                for (int i = MAX_THREADS - 1; i >= 0; i--)
                    if (m_status[i] == ST_FREE) f = i;
                if (f < 0) begin
                    ev = EV_CREATE_FAIL;
                end else begin
                    s           = SLOT_W'(f);
                    ev          = EV_CREATED;
                    subj        = s;
                    m_qleft[s]  = m_quantum;
                    m_prio[s]   = it.priority_req;
                    m_budget[s] = it.total_ticks;
                    if (!it.priority_req) begin
                        low_push(s);
                    end else if (!m_idle && !m_prio[c]) begin
                        requeue_low(c);
                        high_insert(s);
                        dispatch_next();
                    end else if (!m_idle && m_budget[c] > it.total_ticks) begin
                        high_insert(s);
                        high_insert(c);
                        dispatch_next();
                    end else begin
                        high_insert(s);
                    end
                end
            end
            K_TICK: begin
                if (m_idle) begin
                    if (m_high_cnt > 0 || m_low_cnt > 0) begin
                        dispatch_next();
                        ev = EV_SWITCH;
                    end
                end else if (m_budget[c] == 0) begin
                    subj = c;
                    ev   = retire_current(EV_EJECT);
                end else begin
                    m_budget[c]--;
                    if (!m_prio[c]) begin
                        if (m_qleft[c] <= 1) begin
                            requeue_low(c);
                            dispatch_next();
                            ev = EV_SWITCH;
                        end else begin
                            m_qleft[c]--;
                        end
                    end
                end
            end
            K_DISK_REQ: begin
                if (!m_idle && !it.data_cached) begin
                    m_status[c] = ST_WAIT;
                    m_wait[SLOT_W'(m_wait_head + m_wait_cnt)] = c;
                    m_wait_cnt++;
                    dispatch_next();
                    ev   = EV_BLOCK;
                    subj = c;
                end
            end
            K_DISK_DONE: begin
                if (m_wait_cnt > 0) begin
                    s = m_wait[m_wait_head];
                    m_wait_head++;
                    m_wait_cnt--;
                    if (m_status[s] == ST_WAIT) begin
                        ev   = EV_WOKEN;
                        subj = s;
                        if (!m_prio[s]) begin
                            low_push(s);
                        end else begin
                            high_insert(s);
                            if (!m_idle && !m_prio[c]) begin
                                requeue_low(c);
                                dispatch_next();
                            end
                        end
                    end
                end
            end
            K_EXIT: begin
                if (!m_idle) begin
                    subj = c;
                    ev   = retire_current(EV_FINISH);
                end
            end
            K_SET_PRIO: begin
                if (!m_idle) begin
                    m_prio[c] = it.priority_req;
                    if (it.priority_req) m_budget[c] = m_high_budget;
                end
            end
            default: ;
        endcase
        r.event_res  = ev;
        r.running_id = m_idle ? '0 : m_cur;
        r.cpu_idle   = m_idle;
        r.subject_id = subj;
        return r;
    endfunction

    function automatic t_in make_item(logic [2:0] k, logic p, logic [19:0] t, logic d);
        t_in it;
        it.kind         = k;
        it.priority_req = p;
        it.total_ticks  = t;
        it.data_cached  = d;
        return it;
    endfunction

    function automatic t_out make_res(t_event ev, logic [3:0] run, logic idl,
                                      logic [3:0] subj);
        t_out r;
        r.event_res  = ev;
        r.running_id = run;
        r.cpu_idle   = idl;
        r.subject_id = subj;
        return r;
    endfunction

    function automatic t_in random_item();
        int          w;
        logic [2:0]  k;
        logic [19:0] t;
        w = $urandom_range(0, 99);
        if (w < 20)      k = K_CREATE;
        else if (w < 60) k = K_TICK;
        else if (w < 70) k = K_DISK_REQ;
        else if (w < 80) k = K_DISK_DONE;
        else if (w < 88) k = K_EXIT;
        else if (w < 97) k = K_SET_PRIO;
        else             k = 3'($urandom_range(6, 7));
        w = $urandom_range(0, 19);
        if (w == 0)      t = 20'($urandom);
        else if (w == 1) t = 20'hFFFFF;
        else             t = 20'($urandom_range(0, 40));
        return make_item(k, 1'($urandom), t, ($urandom_range(0, 3) == 0));
    endfunction

    task automatic send_item(t_in it, bit typed, t_out res);
        int   gap;
        t_out exp_res;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        exp_res = sched_predict(it);
        if (typed && exp_res != res) begin
            $error("table row disagrees with prediction: table %h predicted %h",
                   res, exp_res);
            n_fail++;
        end
        expected_events.push_back(typed ? res : exp_res);
        n_items++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        start       <= 1'b0;
        wait (expected_events.size() == 0);
        repeat (8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_QUANTUM) m_quantum = data[QUANT_W-1:0];
        else                    m_high_budget = data[BUDGET_BITS-1:0];
    endtask

    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && o_res_valid) begin
            if (expected_events.size() == 0) begin
                $error("unexpected result %h", o_res);
                n_fail++;
            end else begin
                e = expected_events.pop_front();
                n_events++;
                event_seen[o_res.event_res]++;
                if (o_res.event_res != e.event_res) begin
                    $error("event_res expected %0d actual %0d", e.event_res, o_res.event_res);
                    n_fail++;
                end
                if (o_res.running_id != e.running_id) begin
                    $error("running_id expected %0d actual %0d",
                           e.running_id, o_res.running_id);
                    n_fail++;
                end
                if (o_res.cpu_idle != e.cpu_idle) begin
                    $error("cpu_idle expected %0d actual %0d", e.cpu_idle, o_res.cpu_idle);
                    n_fail++;
                end
                if (o_res.subject_id != e.subject_id) begin
                    $error("subject_id expected %0d actual %0d",
                           e.subject_id, o_res.subject_id);
                    n_fail++;
                end
            end
        end
    end

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        t_row rows[$];
        logic [QUANT_W-1:0]     qs [4];
        logic [BUDGET_BITS-1:0] hb [4];
        n_fail   = 0;
        n_items  = 0;
        n_events = 0;
        foreach (event_seen[i]) event_seen[i] = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        sched_reset();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        rows.push_back('{make_item(K_TICK, 0, 0, 0), 1, make_res(EV_NONE, 0, 1, 0)});
        rows.push_back('{make_item(K_EXIT, 0, 0, 0), 1, make_res(EV_NONE, 0, 1, 0)});
        rows.push_back('{make_item(K_DISK_REQ, 0, 0, 0), 1, make_res(EV_NONE, 0, 1, 0)});
        rows.push_back('{make_item(K_SET_PRIO, 1, 0, 0), 1, make_res(EV_NONE, 0, 1, 0)});
        rows.push_back('{make_item(K_DISK_DONE, 0, 0, 0), 1, make_res(EV_NONE, 0, 1, 0)});
        rows.push_back('{make_item(3'd6, 1, 20'hFFFFF, 1), 1, make_res(EV_NONE, 0, 1, 0)});
        rows.push_back('{make_item(3'd7, 0, 0, 0), 1, make_res(EV_NONE, 0, 1, 0)});
        rows.push_back('{make_item(K_CREATE, 0, 0, 0), 1, make_res(EV_CREATED, 0, 1, 0)});
        rows.push_back('{make_item(K_CREATE, 1, 20'hFFFFF, 0), 1,
                         make_res(EV_CREATED, 0, 1, 1)});
        rows.push_back('{make_item(K_TICK, 0, 0, 0), 1, make_res(EV_SWITCH, 1, 0, 0)});
        rows.push_back('{make_item(K_CREATE, 1, 3, 0), 0, '0});
        rows.push_back('{make_item(K_DISK_REQ, 0, 0, 1), 0, '0});
        rows.push_back('{make_item(K_DISK_REQ, 0, 0, 0), 0, '0});
        rows.push_back('{make_item(K_TICK, 0, 0, 0), 0, '0});
        rows.push_back('{make_item(K_DISK_DONE, 0, 0, 0), 0, '0});
        rows.push_back('{make_item(K_SET_PRIO, 0, 0, 0), 0, '0});
        rows.push_back('{make_item(K_SET_PRIO, 1, 0, 0), 0, '0});
        rows.push_back('{make_item(K_CREATE, 0, 1, 0), 0, '0});
        for (int i = 0; i < 14; i++)
            rows.push_back('{make_item(K_CREATE, 0, 20'(i), 0), 0, '0});
        rows.push_back('{make_item(K_EXIT, 0, 0, 0), 0, '0});
        repeat (4) rows.push_back('{make_item(K_TICK, 0, 0, 0), 0, '0});
        foreach (rows[i]) send_item(rows[i].it, rows[i].typed, rows[i].res);

        qs[0] = 8'd1;   hb[0] = '0;
        qs[1] = 8'd255; hb[1] = 20'hFFFFF;
        qs[2] = 8'd0;   hb[2] = 20'd7;
        qs[3] = 8'($urandom_range(2, 20));
        hb[3] = 20'($urandom_range(0, 300));
        for (int ph = 0; ph < 5; ph++) begin
            if (ph > 0) begin
                write_reg(CFG_QUANTUM, CFG_DATA_W'(qs[ph-1]));
                write_reg(CFG_HIGH_BUDGET, CFG_DATA_W'(hb[ph-1]));
            end
            repeat (400) send_item(random_item(), 0, '0);
        end
        start <= 1'b0;

        wait (expected_events.size() == 0);
        repeat (20) @(posedge i_clk);
        $display("Ran %0d items, checked %0d results over 5 register settings.",
                 n_items, n_events);
        $display("Events: created %0d, failed %0d, switched %0d, ejected %0d, finished %0d,",
                 event_seen[EV_CREATED], event_seen[EV_CREATE_FAIL], event_seen[EV_SWITCH],
                 event_seen[EV_EJECT], event_seen[EV_FINISH]);
        $display("  blocked %0d, woken %0d, all done %0d.", event_seen[EV_BLOCK],
                 event_seen[EV_WOKEN], event_seen[EV_ALL_DONE]);
        if (n_fail == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
